/* rtl/pgi_pkg.sv */
// Shared constants and types for the pairwise gravity integrator.
`timescale 1ns / 1ps
`default_nettype none

package pgi_pkg;

	// Fraction bits of positions, velocities and the softening length.
	localparam int FRAC_BITS = 16;

	// G * 1e9 * 2^32, rounded.
	localparam logic [28:0] GM_Q32 = 29'd286659002;

	// Register reset values.
	localparam logic [15:0] TS_RESET   = 16'd655;
	localparam logic [31:0] SOFT_RESET = 32'd13107;

	// Pipelined divider geometry.
	localparam int DIV_NUM_W   = 64;
	localparam int DIV_DEN_W   = 32;
	localparam int DIV_Q_W     = 33;
	localparam int DIV_STAGES  = DIV_Q_W;

	// Square root and normalization.
	localparam int SQRT_STAGES = 32;
	localparam int NORM_STEPS  = 6;

	// Front stages, post stages and total latency from accept to result.
	localparam int FRONT_STAGES = 3;
	localparam int POST_STAGES  = 7;
	localparam int LATENCY      = FRONT_STAGES + SQRT_STAGES + DIV_STAGES + POST_STAGES;

	// Velocity increment scaling.
	localparam int PROD_W   = 96;
	localparam int DV_SHIFT = 127 - 3 * FRAC_BITS;
	localparam int DVQ_W    = PROD_W - DV_SHIFT;

	// Configuration register indexes.
	typedef enum logic {
		CFG_TIME_STEP = 1'b0,
		CFG_SOFTENING = 1'b1
	} cfg_index_t;

endpackage

`default_nettype wire

/* rtl/pgi_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module pgi_div (
	input  logic                          clk,
	input  logic [pgi_pkg::DIV_NUM_W-1:0] num,
	input  logic [pgi_pkg::DIV_DEN_W-1:0] den,
	output logic [pgi_pkg::DIV_Q_W-1:0]   quo
);
	import pgi_pkg::*;

	typedef struct packed {
		logic [DIV_DEN_W-1:0] rem;
		logic [DIV_Q_W-1:0]   low;
		logic [DIV_DEN_W-1:0] den;
	} dstage_t;

	dstage_t st_s [DIV_STAGES];

	// Each stage shifts in one numerator bit and decides one quotient bit.
	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_st
		dstage_t            cur;
		dstage_t            nxt;
		logic [DIV_DEN_W:0] trial;

		if (k == 0) begin : g_first
			assign cur.rem = DIV_DEN_W'(num[DIV_NUM_W-1:DIV_Q_W]);
			assign cur.low = num[DIV_Q_W-1:0];
			assign cur.den = den;
		end else begin : g_rest
			assign cur = st_s[k-1];
		end

		always_comb begin
			trial   = {cur.rem, cur.low[DIV_Q_W-1]};
			nxt.den = cur.den;
			if (trial >= {1'b0, cur.den}) begin
				nxt.rem = DIV_DEN_W'(trial - {1'b0, cur.den});
				nxt.low = {cur.low[DIV_Q_W-2:0], 1'b1};
			end else begin
				nxt.rem = trial[DIV_DEN_W-1:0];
				nxt.low = {cur.low[DIV_Q_W-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk) begin
			st_s[k] <= nxt;
		end
	end

	assign quo = st_s[DIV_STAGES-1].low;

endmodule

`default_nettype wire

/* rtl/pairwise_gravity_integrate_core.sv */
// Top level of the softened pairwise gravity integrator pipeline.
// Throughput: one body pair per cycle; busy stays low, the pipeline never stalls.
// The 32-stage square root and the 33-stage dividers set the depth.
// Reset clears all valid bits and restores both registers to their defaults.
`timescale 1ns / 1ps
`default_nettype none

module pairwise_gravity_integrate_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	output logic                done,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  pgi_pkg::cfg_index_t cfg_index,
	input  logic [31:0]         cfg_data,
	input  logic signed [31:0]  a_pos_x,
	input  logic signed [31:0]  a_pos_y,
	input  logic signed [31:0]  a_vel_x,
	input  logic signed [31:0]  a_vel_y,
	input  logic [31:0]         a_mass,
	input  logic signed [31:0]  b_pos_x,
	input  logic signed [31:0]  b_pos_y,
	input  logic signed [31:0]  b_vel_x,
	input  logic signed [31:0]  b_vel_y,
	input  logic [31:0]         b_mass,
	output logic signed [31:0]  new_a_pos_x,
	output logic signed [31:0]  new_a_pos_y,
	output logic signed [31:0]  new_a_vel_x,
	output logic signed [31:0]  new_a_vel_y,
	output logic signed [31:0]  new_b_pos_x,
	output logic signed [31:0]  new_b_pos_y,
	output logic signed [31:0]  new_b_vel_x,
	output logic signed [31:0]  new_b_vel_y,
	output logic                saturated
);
	import pgi_pkg::*;

	// Lanes: 0 = a.x, 1 = a.y, 2 = b.x, 3 = b.y.
	typedef struct packed {
		logic [3:0][31:0] pos;
		logic [3:0][31:0] vel;
		logic [1:0]       neg;
		logic [1:0][32:0] ad;
		logic [1:0][60:0] c;
		logic [63:0]      dn;
		logic [5:0]       n;
		logic             zero;
	} side_t;

	typedef struct packed {
		logic [63:0] rem;
		logic [63:0] res;
	} root_t;

	localparam logic signed [39:0] MAX32 = 40'sd2147483647;
	localparam logic signed [39:0] MIN32 = -40'sd2147483648;
	localparam logic [127:0]       DV_CAP = 128'd1 << 34;

	// One step of the digit-by-digit square root.
	function automatic root_t sqrt_step(input root_t cur, input logic [63:0] bitv);
		root_t       nxt;
		logic [63:0] trial;
		trial = cur.res + bitv;
		if (cur.rem >= trial) begin
			nxt.rem = cur.rem - trial;
			nxt.res = (cur.res >> 1) + bitv;
		end else begin
			nxt.rem = cur.rem;
			nxt.res = cur.res >> 1;
		end
		return nxt;
	endfunction

	// Clip to 32-bit signed; the top bit of the result flags clipping.
	function automatic logic [32:0] clip32(input logic signed [39:0] v);
		logic [32:0] r;
		if (v > MAX32) begin
			r = {1'b1, MAX32[31:0]};
		end else if (v < MIN32) begin
			r = {1'b1, MIN32[31:0]};
		end else begin
			r = {1'b0, v[31:0]};
		end
		return r;
	endfunction

	logic [15:0] time_step_q;
	logic [31:0] soft_q;
	logic        accept;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q <= TS_RESET;
			soft_q      <= SOFT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_TIME_STEP: time_step_q <= cfg_data[15:0];
				CFG_SOFTENING: soft_q      <= cfg_data;
			endcase
		end
	end

	// Stage 1: separation and its magnitude.
	logic               vld_s1, vld_s2, vld_s3;
	side_t              side_s1, side_s2, side_s3;
	logic [1:0][31:0]   m_s1;
	logic signed [32:0] dx, dy;

	always_comb begin
		dx = {b_pos_x[31], b_pos_x} - {a_pos_x[31], a_pos_x};
		dy = {b_pos_y[31], b_pos_y} - {a_pos_y[31], a_pos_y};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		side_s1.pos   <= {b_pos_y, b_pos_x, a_pos_y, a_pos_x};
		side_s1.vel   <= {b_vel_y, b_vel_x, a_vel_y, a_vel_x};
		side_s1.neg   <= {dy[32], dx[32]};
		side_s1.ad[0] <= dx[32] ? (~dx + 33'd1) : dx;
		side_s1.ad[1] <= dy[32] ? (~dy + 33'd1) : dy;
		side_s1.c     <= '0;
		side_s1.dn    <= '0;
		side_s1.n     <= '0;
		side_s1.zero  <= 1'b0;
		m_s1[0]       <= b_mass;
		m_s1[1]       <= a_mass;
	end

	// Stage 2: squares and mass products.
	logic [1:0][65:0] sq_s2;
	logic [63:0]      sqs_s2;
	logic [1:0][60:0] gm_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		side_s2 <= side_s1;
		for (int i = 0; i < 2; i++) begin
			sq_s2[i] <= 66'(side_s1.ad[i]) * 66'(side_s1.ad[i]);
			gm_s2[i] <= 61'(GM_Q32) * 61'(m_s1[i]);
		end
		sqs_s2 <= 64'(soft_q) * 64'(soft_q);
	end

	// Stage 3: softened squared distance and force coefficients.
	logic [63:0]      d_sum;
	logic [1:0][76:0] c_full;
	logic [63:0]      d_s3;
	side_t            side_d3;

	always_comb begin
		d_sum = 64'(sq_s2[0] >> 2) + 64'(sq_s2[1] >> 2) + (sqs_s2 >> 2);
		for (int i = 0; i < 2; i++) begin
			c_full[i] = 77'(gm_s2[i]) * 77'(time_step_q);
		end
		side_d3      = side_s2;
		side_d3.c[0] = c_full[0][76:16];
		side_d3.c[1] = c_full[1][76:16];
		side_d3.dn   = d_sum;
		side_d3.n    = '0;
		side_d3.zero = ~|d_sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		d_s3    <= d_sum;
		side_s3 <= side_d3;
	end

	// Square root stages; the first ones also normalize the distance term.
	root_t                  rt_s   [SQRT_STAGES];
	side_t                  rtsd_s [SQRT_STAGES];
	logic [SQRT_STAGES-1:0] rt_vld_s;

	for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_root
		localparam int          AMT  = (k < NORM_STEPS) ? (1 << (NORM_STEPS - 1 - k)) : 0;
		localparam logic [63:0] TOPM = ~(64'hFFFF_FFFF_FFFF_FFFF >> AMT);
		localparam logic [63:0] BITV = 64'd1 << (62 - 2 * k);
		root_t rin;
		side_t sin;
		logic  vin;
		side_t snx;

		if (k == 0) begin : g_first
			assign rin.rem = d_s3;
			assign rin.res = '0;
			assign sin     = side_s3;
			assign vin     = vld_s3;
		end else begin : g_rest
			assign rin = rt_s[k-1];
			assign sin = rtsd_s[k-1];
			assign vin = rt_vld_s[k-1];
		end

		always_comb begin
			snx = sin;
			if ((sin.dn & TOPM) == 64'd0) begin
				snx.dn = sin.dn << AMT;
				snx.n  = sin.n + 6'(AMT);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_vld_s[k] <= 1'b0;
			end else begin
				rt_vld_s[k] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			rt_s[k]   <= sqrt_step(rin, BITV);
			rtsd_s[k] <= snx;
		end
	end

	// Dividers: unit vector components and the reciprocal of the distance term.
	side_t                 sq_side;
	logic [31:0]           root;
	logic [DIV_Q_W-1:0]    ux, uy, rq;

	assign sq_side = rtsd_s[SQRT_STAGES-1];
	assign root    = rt_s[SQRT_STAGES-1].res[31:0];

	pgi_div u_div_x (
		.clk (clk),
		.num (64'({sq_side.ad[0], 29'd0})),
		.den (root),
		.quo (ux)
	);

	pgi_div u_div_y (
		.clk (clk),
		.num (64'({sq_side.ad[1], 29'd0})),
		.den (root),
		.quo (uy)
	);

	pgi_div u_div_r (
		.clk (clk),
		.num (64'h8000_0000_0000_0000),
		.den (sq_side.dn[63:32]),
		.quo (rq)
	);

	side_t                 dvsd_s [DIV_STAGES];
	logic [DIV_STAGES-1:0] dv_vld_s;
	side_t                 dv_side;

	// Side data and valid bits follow the dividers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_vld_s <= '0;
		end else begin
			dv_vld_s <= {dv_vld_s[DIV_STAGES-2:0], rt_vld_s[SQRT_STAGES-1]};
		end
	end

	always_ff @(posedge clk) begin
		dvsd_s[0] <= sq_side;
		for (int k = 1; k < DIV_STAGES; k++) begin
			dvsd_s[k] <= dvsd_s[k-1];
		end
	end

	assign dv_side = dvsd_s[DIV_STAGES-1];

	// Stage 4: coefficient times reciprocal, as two partial products.
	logic               vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9, vld_s10;
	side_t              side_s4, side_s5, side_s6, side_s7, side_s8;
	logic [1:0][61:0]   ph_s4;
	logic [1:0][64:0]   pl_s4;
	logic [1:0][DIV_Q_W-1:0] u_s4, u_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
		end else begin
			vld_s4  <= dv_vld_s[DIV_STAGES-1];
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
		end
	end

	always_ff @(posedge clk) begin
		side_s4 <= dv_side;
		u_s4    <= {uy, ux};
		for (int i = 0; i < 2; i++) begin
			ph_s4[i] <= 62'(dv_side.c[i][60:32]) * 62'(rq);
			pl_s4[i] <= 65'(dv_side.c[i][31:0]) * 65'(rq);
		end
	end

	// Stage 5: combine into the per-body force scale.
	logic [1:0][61:0] pa_s5;

	always_ff @(posedge clk) begin
		side_s5 <= side_s4;
		u_s5    <= u_s4;
		for (int i = 0; i < 2; i++) begin
			pa_s5[i] <= ph_s4[i] + 62'(pl_s4[i] >> 32);
		end
	end

	// Stage 6: scale times unit vector component, split in two halves.
	logic [3:0][63:0] puh_s6, pul_s6;

	always_ff @(posedge clk) begin
		side_s6 <= side_s5;
		for (int l = 0; l < 4; l++) begin
			puh_s6[l] <= 64'(pa_s5[l[1]][61:31]) * 64'(u_s5[l[0]]);
			pul_s6[l] <= 64'(pa_s5[l[1]][30:0]) * 64'(u_s5[l[0]]);
		end
	end

	// Stage 7: full product, fixed part of the scaling shift.
	logic [3:0][PROD_W-1:0] prod;
	logic [3:0][DVQ_W-1:0]  dq_s7;

	always_comb begin
		for (int l = 0; l < 4; l++) begin
			prod[l] = (PROD_W'(puh_s6[l]) << 31) + PROD_W'(pul_s6[l]);
		end
	end

	always_ff @(posedge clk) begin
		side_s7 <= side_s6;
		for (int l = 0; l < 4; l++) begin
			dq_s7[l] <= DVQ_W'(prod[l] >> DV_SHIFT);
		end
	end

	// Stage 8: normalization shift, cap and velocity update.
	logic [3:0][127:0]       dsh;
	logic [3:0][34:0]        dvc;
	logic signed [3:0][39:0] vsum;
	logic [3:0][32:0]        vclip;
	logic [3:0][31:0]        vel_d;
	logic                    vsat_d;
	logic                    sat_s8;
	side_t                   side_d8;

	always_comb begin
		vsat_d = 1'b0;
		for (int l = 0; l < 4; l++) begin
			dsh[l] = 128'(dq_s7[l]) >> side_s7.n;
			dvc[l] = (dsh[l] > DV_CAP) ? DV_CAP[34:0] : dsh[l][34:0];
			if (side_s7.neg[l[0]] ^ l[1]) begin
				vsum[l] = 40'($signed(side_s7.vel[l])) - $signed(40'(dvc[l]));
			end else begin
				vsum[l] = 40'($signed(side_s7.vel[l])) + $signed(40'(dvc[l]));
			end
			vclip[l] = clip32(vsum[l]);
			if (side_s7.zero) begin
				vel_d[l] = side_s7.vel[l];
			end else begin
				vel_d[l] = vclip[l][31:0];
				vsat_d   = vsat_d | vclip[l][32];
			end
		end
		side_d8     = side_s7;
		side_d8.vel = vel_d;
	end

	always_ff @(posedge clk) begin
		side_s8 <= side_d8;
		sat_s8  <= vsat_d;
	end

	// Stage 9: position step, truncated toward zero.
	logic [3:0][32:0] vmag;
	logic [3:0][48:0] stp;
	logic [3:0][32:0] step_s9;
	logic [3:0][31:0] pos_s9, vel_s9;
	logic             sat_s9;

	always_comb begin
		for (int l = 0; l < 4; l++) begin
			vmag[l] = side_s8.vel[l][31] ? (~{1'b1, side_s8.vel[l]} + 33'd1)
			                             : {1'b0, side_s8.vel[l]};
			stp[l]  = 49'(vmag[l]) * 49'(time_step_q);
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < 4; l++) begin
			step_s9[l] <= stp[l][48:16];
		end
		pos_s9 <= side_s8.pos;
		vel_s9 <= side_s8.vel;
		sat_s9 <= sat_s8;
	end

	// Stage 10: position update and result registers.
	logic signed [3:0][39:0] psum;
	logic [3:0][32:0]        pclip;
	logic                    psat;
	logic [3:0][31:0]        pos_s10, vel_s10;
	logic                    sat_s10;

	always_comb begin
		psat = 1'b0;
		for (int l = 0; l < 4; l++) begin
			if (vel_s9[l][31]) begin
				psum[l] = 40'($signed(pos_s9[l])) - $signed(40'(step_s9[l]));
			end else begin
				psum[l] = 40'($signed(pos_s9[l])) + $signed(40'(step_s9[l]));
			end
			pclip[l] = clip32(psum[l]);
			psat     = psat | pclip[l][32];
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < 4; l++) begin
			pos_s10[l] <= pclip[l][31:0];
		end
		vel_s10 <= vel_s9;
		sat_s10 <= sat_s9 | psat;
	end

	assign done        = vld_s10;
	assign new_a_pos_x = pos_s10[0];
	assign new_a_pos_y = pos_s10[1];
	assign new_b_pos_x = pos_s10[2];
	assign new_b_pos_y = pos_s10[3];
	assign new_a_vel_x = vel_s10[0];
	assign new_a_vel_y = vel_s10[1];
	assign new_b_vel_x = vel_s10[2];
	assign new_b_vel_y = vel_s10[3];
	assign saturated   = sat_s10;

`ifndef SYNTH
	// Every result word comes from an accepted word; the check looks back by LATENCY.
	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LATENCY))
		else $error("done without matching start");

	// The reciprocal of a normalized distance term has bit 32 or bit 31 set.
	a_recip_range: assert property (@(posedge clk) disable iff (!arst_n)
		dv_vld_s[DIV_STAGES-1] && !dv_side.zero |-> rq[32] || rq[31])
		else $error("reciprocal out of range");

	// Unit vector components stay below two in Q3.30.
	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		dv_vld_s[DIV_STAGES-1] && !dv_side.zero |-> ux[32:31] == 2'b00 && uy[32:31] == 2'b00)
		else $error("unit vector component out of range");
`endif

endmodule

`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for the pairwise gravity integrator pipeline.
`timescale 1ns / 1ps

module tb;
	import pgi_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	typedef struct {
		logic signed [31:0] pos_ax, pos_ay, vel_ax, vel_ay;
		logic [31:0]        mass_a;
		logic signed [31:0] pos_bx, pos_by, vel_bx, vel_by;
		logic [31:0]        mass_b;
	} body_pair_t;

	typedef struct {
		logic [31:0] v[8];
		logic        sat;
	} pair_update_t;

	logic               clk, arst_n, start, busy, done;
	logic               cfg_valid, cfg_ready;
	cfg_index_t         cfg_index;
	logic [31:0]        cfg_data;
	logic signed [31:0] a_pos_x, a_pos_y, a_vel_x, a_vel_y, b_pos_x, b_pos_y, b_vel_x, b_vel_y;
	logic [31:0]        a_mass, b_mass;
	logic signed [31:0] new_a_pos_x, new_a_pos_y, new_a_vel_x, new_a_vel_y;
	logic signed [31:0] new_b_pos_x, new_b_pos_y, new_b_vel_x, new_b_vel_y;
	logic               saturated;

	// Model copy of the two registers.
	logic [15:0] step_q016;
	logic [31:0] soft_len;

	pair_update_t expected_updates[$];
	int  mismatches;
	int  cycles;
	bit  allow_gaps;
	string field_names[8] = '{"new_a_pos_x", "new_a_pos_y", "new_a_vel_x", "new_a_vel_y",
		"new_b_pos_x", "new_b_pos_y", "new_b_vel_x", "new_b_vel_y"};

	pairwise_gravity_integrate_core dut (.*);

	// Clock and cycle counter with the run limit.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic logic [63:0] isqrt(logic [63:0] n);
		logic [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n = n - (res + b);
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// Product shifted right, pinned at all ones when it does not fit 64 bits.
	function automatic logic [63:0] scaled_product(logic [63:0] a, logic [63:0] b, int s);
		logic [127:0] p;
		p = ({64'd0, a} * {64'd0, b}) >> s;
		return (p[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : p[63:0];
	endfunction

	function automatic longint clip32(longint v, ref logic sat);
		if (v > 64'sd2147483647) begin
			sat = 1'b1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			sat = 1'b1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic longint kick(longint v, logic [63:0] dv, bit neg, ref logic sat);
		if (dv > (64'd1 << 34)) dv = 64'd1 << 34;
		return clip32(neg ? v - longint'(dv) : v + longint'(dv), sat);
	endfunction

	function automatic longint drift(longint p, longint v, ref logic sat);
		longint st;
		logic [63:0] mag;
		mag = (v < 0) ? -v : v;
		st = longint'((mag * step_q016) >> 16);
		return clip32(v < 0 ? p - st : p + st, sat);
	endfunction

	// Predicted update of one body pair under the current registers.
	function automatic pair_update_t integrate_pair(body_pair_t bp);
		pair_update_t u;
		longint dx, dy, avx, avy, bvx, bvy;
		logic [63:0] adx, ady, d2, r, ux, uy, dn, recip, ca, cb, pa, pb;
		int n, sh;
		logic sat;
		sat = 1'b0;
		avx = longint'(bp.vel_ax); avy = longint'(bp.vel_ay);
		bvx = longint'(bp.vel_bx); bvy = longint'(bp.vel_by);
		dx = longint'(bp.pos_bx) - longint'(bp.pos_ax);
		dy = longint'(bp.pos_by) - longint'(bp.pos_ay);
		adx = (dx < 0) ? -dx : dx;
		ady = (dy < 0) ? -dy : dy;
		d2 = ((adx * adx) >> 2) + ((ady * ady) >> 2)
			+ (({32'd0, soft_len} * {32'd0, soft_len}) >> 2);
		if (d2 != 0) begin
			r = isqrt(d2);
			ux = (adx << 29) / r;
			uy = (ady << 29) / r;
			n = 0;
			dn = d2;
			while (!dn[63]) begin
				dn <<= 1;
				n++;
			end
			recip = (64'd1 << 63) / (dn >> 32);
			sh = 127 + n - 3 * FRAC_BITS;
			ca = scaled_product(64'(GM_Q32) * bp.mass_b, step_q016, 16);
			cb = scaled_product(64'(GM_Q32) * bp.mass_a, step_q016, 16);
			pa = scaled_product(ca, recip, 32);
			pb = scaled_product(cb, recip, 32);
			avx = kick(avx, scaled_product(pa, ux, sh), dx < 0, sat);
			avy = kick(avy, scaled_product(pa, uy, sh), dy < 0, sat);
			bvx = kick(bvx, scaled_product(pb, ux, sh), dx >= 0, sat);
			bvy = kick(bvy, scaled_product(pb, uy, sh), dy >= 0, sat);
		end
		u.v[0] = 32'(drift(longint'(bp.pos_ax), avx, sat));
		u.v[1] = 32'(drift(longint'(bp.pos_ay), avy, sat));
		u.v[2] = 32'(avx);
		u.v[3] = 32'(avy);
		u.v[4] = 32'(drift(longint'(bp.pos_bx), bvx, sat));
		u.v[5] = 32'(drift(longint'(bp.pos_by), bvy, sat));
		u.v[6] = 32'(bvx);
		u.v[7] = 32'(bvy);
		u.sat = sat;
		return u;
	endfunction

	// Result checker: every done strobe is matched against the oldest expected word.
	always @(posedge clk) begin
		pair_update_t want;
		logic [31:0] got[8];
		bit bad;
		if (arst_n && done) begin
			got = '{new_a_pos_x, new_a_pos_y, new_a_vel_x, new_a_vel_y,
				new_b_pos_x, new_b_pos_y, new_b_vel_x, new_b_vel_y};
			if (expected_updates.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result word at cycle %0d", cycles);
			end else begin
				want = expected_updates.pop_front();
				bad = (want.sat !== saturated);
				for (int k = 0; k < 8; k++) begin
					if (want.v[k] !== got[k]) begin
						bad = 1'b1;
						if (mismatches < 10)
							$display("%s: expected %h, got %h", field_names[k], want.v[k], got[k]);
					end
				end
				if (want.sat !== saturated && mismatches < 10)
					$display("saturated: expected %b, got %b", want.sat, saturated);
				if (bad) mismatches++;
			end
		end
	end

	// Presents one pair and holds it until accepted; start stays high but for gaps.
	task automatic send_pair(body_pair_t bp);
		@(negedge clk);
		start = 1'b1;
		a_pos_x = bp.pos_ax; a_pos_y = bp.pos_ay; a_vel_x = bp.vel_ax; a_vel_y = bp.vel_ay;
		a_mass = bp.mass_a;
		b_pos_x = bp.pos_bx; b_pos_y = bp.pos_by; b_vel_x = bp.vel_bx; b_vel_y = bp.vel_by;
		b_mass = bp.mass_b;
		do @(posedge clk); while (busy);
		expected_updates.insert(expected_updates.size(), integrate_pair(bp));
		if (allow_gaps && $urandom_range(0, 3) == 0) begin
			@(negedge clk);
			start = 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
	endtask

	task automatic drain;
		@(negedge clk);
		start = 1'b0;
		while (expected_updates.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_reg(cfg_index_t idx, logic [31:0] val);
		drain();
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_TIME_STEP) step_q016 = val[15:0];
		else soft_len = val;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic body_pair_t make_pair(int sel);
		body_pair_t bp;
		bp = '{$urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom, $urandom};
		case (sel)
			0: ; // fully random words
			1: begin
				// Nearby bodies with modest x speeds, the usual workload.
				bp.pos_bx = bp.pos_ax + $signed($urandom_range(0, 1 << 22)) - (1 << 21);
				bp.pos_by = bp.pos_ay + $signed($urandom_range(0, 1 << 22)) - (1 << 21);
				bp.vel_ax = $signed($urandom_range(0, 1 << 24)) - (1 << 23);
				bp.vel_bx = $signed($urandom_range(0, 1 << 24)) - (1 << 23);
				bp.mass_a = $urandom >> $urandom_range(0, 31);
				bp.mass_b = $urandom >> $urandom_range(0, 31);
			end
			default: begin
				// Very close bodies, strong pull.
				bp.pos_bx = bp.pos_ax + $signed($urandom_range(0, 64)) - 32;
				bp.pos_by = bp.pos_ay + $signed($urandom_range(0, 64)) - 32;
			end
		endcase
		return bp;
	endfunction

	function automatic body_pair_t uniform_pair(logic [31:0] p, logic [31:0] v, logic [31:0] m);
		return '{p, p, v, v, m, p, p, v, v, m};
	endfunction

	// Corner values of every field under the default registers.
	task automatic test_field_extremes;
		send_pair(uniform_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
		send_pair(uniform_pair(32'h8000_0000, 32'h8000_0000, 32'd0));
		send_pair('{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF});
		send_pair('{32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 32'd1000,
			32'h8000_0000, 32'h0, 32'h0, 32'h0, 32'd1000});
		send_pair(uniform_pair(32'd0, 32'd0, 32'd0));
		send_pair('{32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF,
			32'h0, 32'h0001_0000, 32'h0, 32'h0, 32'hFFFF_FFFF});
	endtask

	// Zero time step: nothing moves.
	task automatic test_zero_step;
		write_reg(CFG_TIME_STEP, 32'd0);
		send_pair(make_pair(2));
		send_pair(uniform_pair(32'h1234_5678, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
		send_pair(make_pair(0));
	endtask

	// No softening: coincident bodies feel no force; near ones blow up and clip.
	task automatic test_no_softening;
		write_reg(CFG_SOFTENING, 32'd0);
		write_reg(CFG_TIME_STEP, 32'hFFFF);
		send_pair(uniform_pair(32'h0040_0000, 32'h7FFF_0000, 32'hFFFF_FFFF));
		send_pair('{32'h0, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF,
			32'h1, 32'h1, 32'h0, 32'h0, 32'hFFFF_FFFF});
		send_pair(make_pair(2));
		send_pair(make_pair(1));
	endtask

	task automatic test_max_softening;
		write_reg(CFG_SOFTENING, 32'hFFFF_FFFF);
		send_pair(make_pair(2));
		send_pair(make_pair(0));
		send_pair(uniform_pair(32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF));
	endtask

	// Random traffic over a series of register settings.
	task automatic test_random_traffic;
		logic [31:0] steps[5] = '{32'd655, 32'd1, 32'hFFFF, 32'd0, 32'd6554};
		logic [31:0] softs[5] = '{32'd13107, 32'd0, 32'hFFFF_FFFF, 32'h0001_0000, 32'd13107};
		for (int ph = 0; ph < 5; ph++) begin
			write_reg(CFG_TIME_STEP, steps[ph] == 6554 ? $urandom_range(0, 65535) : steps[ph]);
			write_reg(CFG_SOFTENING, ph == 4 ? $urandom : softs[ph]);
			allow_gaps = (ph < 4);
			for (int i = 0; i < 225; i++) begin
				send_pair(make_pair($urandom_range(0, 9) < 6 ? 1 : $urandom_range(0, 9) < 5 ? 0 : 2));
				// Hold off once until the pipeline has emptied.
				if (ph == 1 && i == 100) begin
					@(negedge clk);
					start = 1'b0;
					while (expected_updates.size() != 0) @(posedge clk);
				end
			end
		end
	endtask

	initial begin
		int waited;
		arst_n = 1'b0;
		start = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_TIME_STEP;
		cfg_data = '0;
		{a_pos_x, a_pos_y, a_vel_x, a_vel_y, a_mass} = '0;
		{b_pos_x, b_pos_y, b_vel_x, b_vel_y, b_mass} = '0;
		step_q016 = TS_RESET;
		soft_len = SOFT_RESET;
		mismatches = 0;
		cycles = 0;
		allow_gaps = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		test_field_extremes();
		test_zero_step();
		test_no_softening();
		test_max_softening();
		test_random_traffic();

		@(negedge clk);
		start = 1'b0;
		waited = 0;
		while (expected_updates.size() != 0 && waited < 4 * LATENCY) begin
			@(posedge clk);
			waited++;
		end
		repeat (LATENCY + 4) @(posedge clk);
		if (mismatches == 0 && expected_updates.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
